>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gba_pkg.sv
// Shared constants, codes and controller/datapath bundles of the grid block allocator.
// Depends on nothing.
`default_nettype none

package gba_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int MAP_W    = 64;                 // bits of one occupancy row
  localparam int ROW_AW   = $clog2(MAX_ROWS);   // occupancy memory address width
  localparam int CNT_W    = 7;                  // grid size and span fields
  localparam int DIM_W    = 11;                 // block size registers
  localparam int PIX_W    = 16;                 // pixel fields
  localparam int QUO_W    = PIX_W + 1;          // ceiling quotient width
  localparam int WIDE_W   = QUO_W + 1;          // compares against spans

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_OCCUPY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BLOCK_W   = 2'd0,
    REG_BLOCK_H   = 2'd1,
    REG_INIT_COLS = 2'd2,
    REG_INIT_ROWS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic latch;
    logic init;
    logic div_start_w;
    logic div_start_h;
    logic div_store_w;
    logic div_store_h;
    logic srch_start;
    logic row_start;
    logic srch_acc;
    logic hit_take;
    logic y_next;
    logic grow;
    logic rect_setup;
    logic rect_rd;
    logic rect_wr;
    logic mul;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic div_done;
    logic row_over;
    logic k_last;
    logic cand_any;
    logic grow_ok;
    logic rect_empty;
    logic rect_last;
  } dp_status_t;

  // Mask of the low n bits of a row, all ones from the full row width up.
  function automatic logic [MAP_W-1:0] span_mask(input logic [QUO_W-1:0] n);
    logic [MAP_W-1:0] m;
    if (n >= QUO_W'(MAP_W)) begin
      m = '1;
    end else begin
      m = (MAP_W'(1) << n[$clog2(MAP_W)-1:0]) - MAP_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/gba_div.sv
// Restoring divider, one quotient bit per cycle, for the block span ceilings.
// Depends on gba_pkg.
`default_nettype none

module gba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gba_pkg::QUO_W-1:0]  dividend_i,
  input  logic [gba_pkg::DIM_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [gba_pkg::QUO_W-1:0]  quotient_o
);
  import gba_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] quo_q;
  logic [DIM_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DIM_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIM_W'(trial - {1'b0, den_q}) : trial[DIM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/gba_datapath.sv
// Datapath: configuration, occupancy map with row valid bits, search window,
// rectangle read-modify-write, pixel products and the result register.
// Depends on gba_pkg, gba_ram and gba_div.
`default_nettype none

module gba_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_addr_i,
  input  logic [gba_pkg::DIM_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                  command_i,
  input  logic [15:0]                 request_width_i,
  input  logic [15:0]                 request_height_i,
  input  logic [5:0]                  start_col_i,
  input  logic [5:0]                  start_row_i,
  input  logic [6:0]                  span_cols_i,
  input  logic [6:0]                  span_rows_i,
  input  gba_pkg::ctrl_cmd_t          ctrl_i,
  output gba_pkg::dp_status_t         stat_o,
  output logic                        status_o,
  output logic [5:0]                  found_col_o,
  output logic [5:0]                  found_row_o,
  output logic [15:0]                 pixel_x_o,
  output logic [15:0]                 pixel_y_o,
  output logic [6:0]                  used_cols_o,
  output logic [6:0]                  used_rows_o,
  output logic                        grew_o,
  output logic [6:0]                  grid_cols_o,
  output logic [6:0]                  grid_rows_o
);
  import gba_pkg::*;

  // Configuration.
  logic [DIM_W-1:0] bw_q, bh_q;
  logic [CNT_W-1:0] icols_q, irows_q;
  // Latched item.
  cmd_e             cmd_q;
  logic [PIX_W-1:0] rw_q, rh_q;
  logic [5:0]       c0_q, r0_q;
  logic [CNT_W-1:0] nc_q, nr_q;
  // Grid state.
  logic [CNT_W-1:0] cols_q, rows_q;
  logic [MAP_W-1:0] valid_q;
  // Search.
  logic [QUO_W-1:0] sc_q, sr_q;
  logic [CNT_W-1:0] y_q, k_q;
  logic [MAP_W-1:0] win_q, free_q;
  logic [5:0]       fc_q, fr_q;
  logic             hit_q, grew_q;
  // Rectangle update.
  logic [CNT_W-1:0] rr_q, rr1_q;
  logic [MAP_W-1:0] rmask_q;
  logic             rempty_q;
  logic [ROW_AW-1:0] rd_row_q;
  // Products.
  logic [PIX_W-1:0] px_q, py_q;

  logic [DIM_W-1:0] bw_eff, bh_eff;
  logic [QUO_W-1:0] dividend, quotient;
  logic             div_done;
  logic [ROW_AW-1:0] raddr;
  logic [CNT_W-1:0] yk;
  logic [MAP_W-1:0] rdata, rowv, smask, win_row, colok, cand, wdata;
  logic [5:0]       first;
  logic [WIDE_W-1:0] c1w, r1w, c0w, r0w, nw, mw;
  logic [QUO_W-1:0] nread;
  logic [QUO_W:0]   prod_x, prod_y;

  assign bw_eff = (bw_q == '0) ? DIM_W'(1) : bw_q;
  assign bh_eff = (bh_q == '0) ? DIM_W'(1) : bh_q;

  assign dividend = ctrl_i.div_start_h
                  ? QUO_W'({1'b0, rh_q} + {6'b0, bh_eff} - QUO_W'(1))
                  : QUO_W'({1'b0, rw_q} + {6'b0, bw_eff} - QUO_W'(1));

  gba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start_w | ctrl_i.div_start_h),
    .dividend_i (dividend),
    .divisor_i  (ctrl_i.div_start_h ? bh_eff : bw_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign yk    = y_q + k_q;
  assign raddr = ctrl_i.rect_rd ? rr_q[ROW_AW-1:0] : yk[ROW_AW-1:0];
  assign wdata = (cmd_q == CMD_FREE) ? (rowv & ~rmask_q) : (rowv | rmask_q);

  gba_ram #(.Width(MAP_W), .Depth(MAX_ROWS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.rect_wr),
    .waddr_i (rr_q[ROW_AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Rows never written since init read as empty.
  assign rowv  = valid_q[rd_row_q] ? rdata : '0;
  assign smask = span_mask(sc_q);

  always_comb begin
    for (int x = 0; x < MAP_W; x++) begin
      win_row[x] = ~|(rowv & (smask << x));
      colok[x]   = (x < int'(cols_q)) &&
                   (WIDE_W'(x) + {1'b0, sc_q} <= WIDE_W'(cols_q));
    end
  end

  assign cand = free_q & win_q & colok;

  always_comb begin
    first = '0;
    for (int x = MAP_W - 1; x >= 0; x--) begin
      if (cand[x]) begin
        first = 6'(x);
      end
    end
  end

  assign nread = (sr_q == '0) ? QUO_W'(1) : sr_q;

  // Rectangle bounds, clipped to the grid.
  always_comb begin
    if (cmd_q == CMD_ALLOC) begin
      c0w = WIDE_W'(fc_q);
      r0w = WIDE_W'(fr_q);
      nw  = WIDE_W'(sc_q);
      mw  = WIDE_W'(sr_q);
    end else begin
      c0w = WIDE_W'(c0_q);
      r0w = WIDE_W'(r0_q);
      nw  = WIDE_W'(nc_q);
      mw  = WIDE_W'(nr_q);
    end
    c1w = c0w + nw;
    r1w = r0w + mw;
    if (c1w > WIDE_W'(cols_q)) c1w = WIDE_W'(cols_q);
    if (r1w > WIDE_W'(rows_q)) r1w = WIDE_W'(rows_q);
  end

  assign prod_x = (QUO_W + 1)'({11'b0, fc_q} * {6'b0, bw_eff});
  assign prod_y = (QUO_W + 1)'({11'b0, fr_q} * {6'b0, bh_eff});

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.div_done   = div_done;
    stat_o.row_over   = (y_q >= rows_q) ||
                        (WIDE_W'(y_q) + {1'b0, sr_q} > WIDE_W'(rows_q));
    stat_o.k_last     = WIDE_W'(k_q) + WIDE_W'(1) >= {1'b0, nread};
    stat_o.cand_any   = |cand;
    stat_o.grow_ok    = !grew_q && (sc_q != '0) && (sr_q != '0) &&
                        (WIDE_W'(cols_q) + {1'b0, sc_q} <= WIDE_W'(MAX_COLS)) &&
                        (WIDE_W'(rows_q) + {1'b0, sr_q} <= WIDE_W'(MAX_ROWS));
    stat_o.rect_empty = rempty_q;
    stat_o.rect_last  = ({1'b0, rr_q} + 8'd1) >= {1'b0, rr1_q};
  end

  // Control-side registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q    <= DIM_W'(16);
      bh_q    <= DIM_W'(16);
      icols_q <= CNT_W'(8);
      irows_q <= CNT_W'(8);
      cols_q  <= '0;
      rows_q  <= '0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      grew_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_BLOCK_W:   bw_q    <= cfg_wdata_i;
          REG_BLOCK_H:   bh_q    <= cfg_wdata_i;
          REG_INIT_COLS: icols_q <= cfg_wdata_i[CNT_W-1:0];
          REG_INIT_ROWS: irows_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.latch) begin
        hit_q  <= 1'b0;
        grew_q <= 1'b0;
      end
      if (ctrl_i.init) begin
        valid_q <= '0;
        cols_q  <= (icols_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : icols_q;
        rows_q  <= (irows_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : irows_q;
      end
      if (ctrl_i.grow) begin
        cols_q <= CNT_W'(WIDE_W'(cols_q) + {1'b0, sc_q});
        rows_q <= CNT_W'(WIDE_W'(rows_q) + {1'b0, sr_q});
        grew_q <= 1'b1;
      end
      if (ctrl_i.hit_take) begin
        hit_q <= 1'b1;
      end
      if (ctrl_i.rect_wr) begin
        valid_q[rr_q[ROW_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_row_q <= raddr;
    if (ctrl_i.latch) begin
      cmd_q <= cmd_e'(command_i);
      rw_q  <= request_width_i;
      rh_q  <= request_height_i;
      c0_q  <= start_col_i;
      r0_q  <= start_row_i;
      nc_q  <= span_cols_i;
      nr_q  <= span_rows_i;
    end
    if (ctrl_i.div_store_w && div_done) sc_q <= quotient;
    if (ctrl_i.div_store_h && div_done) sr_q <= quotient;
    if (ctrl_i.srch_start) y_q <= '0;
    if (ctrl_i.y_next) y_q <= y_q + CNT_W'(1);
    if (ctrl_i.row_start) begin
      win_q <= '1;
      k_q   <= '0;
    end
    if (ctrl_i.srch_acc) begin
      if (k_q == '0) free_q <= ~rowv;
      if (QUO_W'(k_q) < sr_q) win_q <= win_q & win_row;
      k_q <= k_q + CNT_W'(1);
    end
    if (ctrl_i.hit_take) begin
      fc_q <= first;
      fr_q <= y_q[5:0];
    end
    if (ctrl_i.rect_setup) begin
      rr_q     <= CNT_W'(r0w);
      rr1_q    <= CNT_W'(r1w);
      rempty_q <= (c0w >= c1w) || (r0w >= r1w);
      rmask_q  <= span_mask(QUO_W'(c1w - c0w)) << c0w[5:0];
    end
    if (ctrl_i.rect_wr) rr_q <= rr_q + CNT_W'(1);
    if (ctrl_i.mul) begin
      px_q <= (prod_x > (QUO_W + 1)'(16'hFFFF)) ? 16'hFFFF : prod_x[PIX_W-1:0];
      py_q <= (prod_y > (QUO_W + 1)'(16'hFFFF)) ? 16'hFFFF : prod_y[PIX_W-1:0];
    end
    if (ctrl_i.out_load) begin
      status_o    <= (cmd_q == CMD_ALLOC) && !hit_q;
      found_col_o <= (cmd_q == CMD_ALLOC && hit_q) ? fc_q : '0;
      found_row_o <= (cmd_q == CMD_ALLOC && hit_q) ? fr_q : '0;
      pixel_x_o   <= (cmd_q == CMD_ALLOC && hit_q) ? px_q : '0;
      pixel_y_o   <= (cmd_q == CMD_ALLOC && hit_q) ? py_q : '0;
      used_cols_o <= (cmd_q == CMD_ALLOC && hit_q) ? sc_q[CNT_W-1:0] : '0;
      used_rows_o <= (cmd_q == CMD_ALLOC && hit_q) ? sr_q[CNT_W-1:0] : '0;
      grew_o      <= (cmd_q == CMD_ALLOC) && hit_q && grew_q;
      grid_cols_o <= cols_q;
      grid_rows_o <= rows_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gba_ctrl.sv
// Controller state machine: sequences division, search, growth, rectangle
// update and the result handshake. Depends on gba_pkg.
`default_nettype none

module gba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  gba_pkg::dp_status_t stat_i,
  output gba_pkg::ctrl_cmd_t  ctrl_o
);
  import gba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INIT, S_DIVW_GO, S_DIVW_WAIT, S_DIVH_GO, S_DIVH_WAIT,
    S_SINIT, S_ROWCHK, S_RD, S_ACC, S_EVAL, S_MISS, S_RSET, S_RCHK, S_RWR,
    S_MUL, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  state_e rect_done;

  assign rect_done = (stat_i.cmd == CMD_ALLOC) ? S_MUL : S_OUT;

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_INIT:  state_d = S_INIT;
          CMD_ALLOC: state_d = S_DIVW_GO;
          default:   state_d = S_RSET;
        endcase
      end
      S_INIT: begin
        ctrl_o.init = 1'b1;
        state_d     = S_OUT;
      end
      S_DIVW_GO: begin
        ctrl_o.div_start_w = 1'b1;
        state_d            = S_DIVW_WAIT;
      end
      S_DIVW_WAIT: begin
        ctrl_o.div_store_w = 1'b1;
        if (stat_i.div_done) state_d = S_DIVH_GO;
      end
      S_DIVH_GO: begin
        ctrl_o.div_start_h = 1'b1;
        state_d            = S_DIVH_WAIT;
      end
      S_DIVH_WAIT: begin
        ctrl_o.div_store_h = 1'b1;
        if (stat_i.div_done) state_d = S_SINIT;
      end
      S_SINIT: begin
        ctrl_o.srch_start = 1'b1;
        state_d           = S_ROWCHK;
      end
      S_ROWCHK: begin
        if (stat_i.row_over) begin
          state_d = S_MISS;
        end else begin
          ctrl_o.row_start = 1'b1;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        ctrl_o.srch_acc = 1'b1;
        state_d         = stat_i.k_last ? S_EVAL : S_RD;
      end
      S_EVAL: begin
        if (stat_i.cand_any) begin
          ctrl_o.hit_take = 1'b1;
          state_d         = S_RSET;
        end else begin
          ctrl_o.y_next = 1'b1;
          state_d       = S_ROWCHK;
        end
      end
      S_MISS: begin
        if (stat_i.grow_ok) begin
          ctrl_o.grow = 1'b1;
          state_d     = S_SINIT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RSET: begin
        ctrl_o.rect_setup = 1'b1;
        state_d           = S_RCHK;
      end
      S_RCHK: begin
        if (stat_i.rect_empty) begin
          state_d = rect_done;
        end else begin
          ctrl_o.rect_rd = 1'b1;
          state_d        = S_RWR;
        end
      end
      S_RWR: begin
        ctrl_o.rect_wr = 1'b1;
        state_d        = stat_i.rect_last ? rect_done : S_RCHK;
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/grid_block_allocator.sv
// Grid block allocator: first-fit rectangle allocation on a 64 by 64 block map.
// Init clears the map and loads the grid size; free or occupy reads and rewrites each clipped row.
// Allocate first divides the pixel size into block spans, then tests each candidate start row
// by reading the map rows under its window one by one, then marks the found rectangle row by
// row. One item is in work at a time; the result register frees the input.
// Reset is asynchronous: the grid is 0 by 0, every map row reads as empty.
`default_nettype none

module grid_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,
  // Command channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] request_width_i,
  input  logic [15:0] request_height_i,
  input  logic [5:0]  start_col_i,
  input  logic [5:0]  start_row_i,
  input  logic [6:0]  span_cols_i,
  input  logic [6:0]  span_rows_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [5:0]  found_col_o,
  output logic [5:0]  found_row_o,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [6:0]  used_cols_o,
  output logic [6:0]  used_rows_o,
  output logic        grew_o,
  output logic [6:0]  grid_cols_o,
  output logic [6:0]  grid_rows_o
);
  import gba_pkg::*;

  // The controller only issues strobes; every data value lives in the datapath.
  ctrl_cmd_t  ctrl;
  dp_status_t stat;

  // The state machine walks each allocate item through division of the pixel size
  // into block spans, the row-major candidate search (with one grid growth
  // retry), the rectangle read-modify-write and finally the result register.
  gba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // The datapath holds the occupancy memory with one valid bit per row, so
  // init clears the whole map at once without a sweep.
  gba_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .request_width_i  (request_width_i),
    .request_height_i (request_height_i),
    .start_col_i      (start_col_i),
    .start_row_i      (start_row_i),
    .span_cols_i      (span_cols_i),
    .span_rows_i      (span_rows_i),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .status_o         (status_o),
    .found_col_o      (found_col_o),
    .found_row_o      (found_row_o),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .used_cols_o      (used_cols_o),
    .used_rows_o      (used_rows_o),
    .grew_o           (grew_o),
    .grid_cols_o      (grid_cols_o),
    .grid_rows_o      (grid_rows_o)
  );

endmodule

`default_nettype wire

>>> rtl/gba_checker.sv
// Port-level checker for the grid block allocator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        status_i,
  input logic [5:0]  found_col_i,
  input logic [15:0] pixel_x_i,
  input logic [6:0]  used_cols_i,
  input logic [6:0]  used_rows_i,
  input logic        grew_i,
  input logic [6:0]  grid_cols_i,
  input logic [6:0]  grid_rows_i
);

  `GBA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(status_i) && $stable(pixel_x_i))
  `GBA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_i && status_i, found_col_i == 6'd0 && pixel_x_i == 16'd0 && used_cols_i == 7'd0 && !grew_i)
  `GBA_ASSERT_IMP(a_fit, clk_i, rst_ni, out_valid_i && !status_i, ({1'b0, found_col_i} + used_cols_i <= grid_cols_i) && (used_rows_i <= grid_rows_i))
  `GBA_ASSERT_IMP(a_grid_max, clk_i, rst_ni, out_valid_i, grid_cols_i <= 7'd64 && grid_rows_i <= 7'd64)

endmodule

bind grid_block_allocator gba_checker u_gba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_i    (status_o),
  .found_col_i (found_col_o),
  .pixel_x_i   (pixel_x_o),
  .used_cols_i (used_cols_o),
  .used_rows_i (used_rows_o),
  .grew_i      (grew_o),
  .grid_cols_i (grid_cols_o),
  .grid_rows_i (grid_rows_o)
);

`default_nettype wire

>>> tb/tb_grid_block_allocator.sv
// Testbench of the grid block allocator: directed and random command items,
// checked against a cycle-free predictor of the occupancy map. Depends on gba_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_grid_block_allocator;
  import gba_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;

  // One result item as the block should report it.
  typedef struct {
    bit          status;
    bit [5:0]    found_col;
    bit [5:0]    found_row;
    bit [15:0]   pixel_x;
    bit [15:0]   pixel_y;
    bit [6:0]    used_cols;
    bit [6:0]    used_rows;
    bit          grew;
    bit [6:0]    grid_cols;
    bit [6:0]    grid_rows;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [10:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [15:0] request_width_i;
  logic [15:0] request_height_i;
  logic [5:0]  start_col_i;
  logic [5:0]  start_row_i;
  logic [6:0]  span_cols_i;
  logic [6:0]  span_rows_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [5:0]  found_col_o;
  logic [5:0]  found_row_o;
  logic [15:0] pixel_x_o;
  logic [15:0] pixel_y_o;
  logic [6:0]  used_cols_o;
  logic [6:0]  used_rows_o;
  logic        grew_o;
  logic [6:0]  grid_cols_o;
  logic [6:0]  grid_rows_o;

  grid_block_allocator u_top (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: the occupancy map, the grid size and the registers.
  bit [63:0]   occ_map [64];
  int unsigned grid_c, grid_r;
  int unsigned blk_w, blk_h, init_c, init_r;

  alloc_result_t expected_results[$];
  int          error_count;
  int          tx_idle_pct, rx_idle_pct;
  int          rx_hold_cycles;
  int          idle_count;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic bit [63:0] low_ones(int unsigned n);
    return (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
  endfunction

  // Row-major first fit: the first free cell whose rectangle is free and
  // inside the grid. A free cell whose rectangle would leave the grid ends
  // the scan of that row.
  function automatic bit first_fit(int unsigned sc, int unsigned sr,
                                   output int unsigned fc, output int unsigned fr);
    bit [63:0] m;
    bit        clear;
    fc = 0;
    fr = 0;
    if (sc > grid_c || sr > grid_r) return 1'b0;
    for (int unsigned y = 0; y < grid_r; y++) begin
      for (int unsigned x = 0; x < grid_c; x++) begin
        if (occ_map[y][x]) continue;
        if (x + sc > grid_c || y + sr > grid_r) break;
        m = low_ones(sc) << x;
        clear = 1'b1;
        for (int unsigned k = 0; k < sr; k++) begin
          if ((occ_map[y + k] & m) != 0) clear = 1'b0;
        end
        if (clear) begin
          fc = x;
          fr = y;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Sets or clears a block rectangle clipped to the current grid.
  function automatic void mark_rect(int unsigned c0, int unsigned r0,
                                    int unsigned sc, int unsigned sr, bit fill);
    int unsigned c1, r1;
    bit [63:0]   m;
    c1 = (c0 + sc > grid_c) ? grid_c : c0 + sc;
    r1 = (r0 + sr > grid_r) ? grid_r : r0 + sr;
    if (c0 >= c1 || r0 >= r1) return;
    m = low_ones(c1 - c0) << c0;
    for (int unsigned r = r0; r < r1; r++) begin
      occ_map[r] = fill ? (occ_map[r] | m) : (occ_map[r] & ~m);
    end
  endfunction

  // Applies one command item to the predictor and returns its result.
  function automatic alloc_result_t apply_command(cmd_e cmd, int unsigned rw,
      int unsigned rh, int unsigned c0, int unsigned r0, int unsigned sc_in,
      int unsigned sr_in);
    alloc_result_t res;
    int unsigned   bw, bh, sc, sr, fc, fr, px, py;
    bit            hit;
    res = '{default: 0};
    case (cmd)
      CMD_INIT: begin
        foreach (occ_map[i]) occ_map[i] = '0;
        grid_c = (init_c > MAX_COLS) ? MAX_COLS : init_c;
        grid_r = (init_r > MAX_ROWS) ? MAX_ROWS : init_r;
      end
      CMD_ALLOC: begin
        bw = (blk_w == 0) ? 1 : blk_w;
        bh = (blk_h == 0) ? 1 : blk_h;
        sc = (rw + bw - 1) / bw;
        sr = (rh + bh - 1) / bh;
        hit = first_fit(sc, sr, fc, fr);
        if (!hit && sc != 0 && sr != 0 && grid_c + sc <= MAX_COLS &&
            grid_r + sr <= MAX_ROWS) begin
          grid_c += sc;
          grid_r += sr;
          res.grew = 1'b1;
          hit = first_fit(sc, sr, fc, fr);
        end
        if (hit) begin
          mark_rect(fc, fr, sc, sr, 1'b1);
          px = fc * bw;
          py = fr * bh;
          res.found_col = 6'(fc);
          res.found_row = 6'(fr);
          res.pixel_x   = (px > 65535) ? 16'hFFFF : 16'(px);
          res.pixel_y   = (py > 65535) ? 16'hFFFF : 16'(py);
          res.used_cols = 7'(sc);
          res.used_rows = 7'(sr);
        end else begin
          res.status = 1'b1;
          res.grew   = 1'b0;
        end
      end
      default: mark_rect(c0, r0, sc_in, sr_in, cmd == CMD_OCCUPY);
    endcase
    res.grid_cols = 7'(grid_c);
    res.grid_rows = 7'(grid_r);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------
  // Offers one item, holding it until the block takes it. Valid stays high
  // into the next item when no gap is drawn.
  task automatic send_command(cmd_e cmd, int unsigned rw, int unsigned rh,
                              int unsigned c0, int unsigned r0,
                              int unsigned sc, int unsigned sr);
    int unsigned gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    request_width_i  <= 16'(rw);
    request_height_i <= 16'(rh);
    start_col_i      <= 6'(c0);
    start_row_i      <= 6'(r0);
    span_cols_i      <= 7'(sc);
    span_rows_i      <= 7'(sr);
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_command(cmd, 16'(rw), 16'(rh), 6'(c0), 6'(r0),
                                             7'(sc), 7'(sr)));
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers are written only with nothing outstanding and the block at rest.
  task automatic write_config(cfg_reg_e idx, int unsigned value);
    drop_valid();
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= 11'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BLOCK_W:   blk_w  = value & 11'h7FF;
      REG_BLOCK_H:   blk_h  = value & 11'h7FF;
      REG_INIT_COLS: init_c = value & 7'h7F;
      default:       init_r = value & 7'h7F;
    endcase
  endtask

  task automatic set_geometry(int unsigned bw, int unsigned bh,
                              int unsigned ic, int unsigned ir);
    write_config(REG_BLOCK_W, bw);
    write_config(REG_BLOCK_H, bh);
    write_config(REG_INIT_COLS, ic);
    write_config(REG_INIT_ROWS, ir);
  endtask

  // ---------------------------------------------------------------------
  // Receiving side and checking
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_stall_i    <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o    !== want.status)    report_mismatch("status", status_o, want.status);
        if (found_col_o !== want.found_col) report_mismatch("found_col", found_col_o,
                                                           want.found_col);
        if (found_row_o !== want.found_row) report_mismatch("found_row", found_row_o,
                                                           want.found_row);
        if (pixel_x_o   !== want.pixel_x)   report_mismatch("pixel_x", pixel_x_o, want.pixel_x);
        if (pixel_y_o   !== want.pixel_y)   report_mismatch("pixel_y", pixel_y_o, want.pixel_y);
        if (used_cols_o !== want.used_cols) report_mismatch("used_cols", used_cols_o,
                                                           want.used_cols);
        if (used_rows_o !== want.used_rows) report_mismatch("used_rows", used_rows_o,
                                                           want.used_rows);
        if (grew_o      !== want.grew)      report_mismatch("grew", grew_o, want.grew);
        if (grid_cols_o !== want.grid_cols) report_mismatch("grid_cols", grid_cols_o,
                                                           want.grid_cols);
        if (grid_rows_o !== want.grid_rows) report_mismatch("grid_rows", grid_rows_o,
                                                           want.grid_rows);
      end
    end
  end

  // The watchdog restarts on every handshake and on every register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i ||
        !rst_ni) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Field extremes, every command, zero spans, growth limits and clipping,
  // all on the reset geometry of 16 by 16 pixel blocks and an 8 by 8 grid.
  task automatic test_directed();
    send_command(CMD_ALLOC, 16, 16, 0, 0, 0, 0);          // empty grid grows
    send_command(CMD_INIT, 16'hFFFF, 16'hFFFF, 63, 63, 127, 127);
    send_command(CMD_ALLOC, 16, 16, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 17, 1, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 0, 0, 0, 0, 0, 0);            // zero span, nothing marked
    send_command(CMD_ALLOC, 0, 40, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0); // growth past the limit
    send_command(CMD_OCCUPY, 0, 0, 0, 0, 64, 64);
    send_command(CMD_ALLOC, 0, 0, 0, 0, 0, 0);            // zero span with no free cell
    send_command(CMD_ALLOC, 1, 1, 0, 0, 0, 0);            // full map grows
    send_command(CMD_FREE, 0, 0, 63, 63, 64, 64);          // wholly outside the grid
    send_command(CMD_FREE, 0, 0, 2, 3, 4, 100);            // clipped at the bottom
    send_command(CMD_ALLOC, 64, 16, 0, 0, 0, 0);
    send_command(CMD_OCCUPY, 0, 0, 5, 0, 0, 5);            // zero-width rectangle
    send_command(CMD_FREE, 0, 0, 0, 0, 127, 127);
    send_command(CMD_ALLOC, 16'h8000, 16'h0100, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 16'h7FFF, 1, 0, 0, 0, 0);
    send_command(CMD_OCCUPY, 0, 0, 42, 21, 64, 1);
    send_command(CMD_ALLOC, 1000, 1000, 0, 0, 0, 0);
  endtask

  // Register extremes: zero block size, the widest register values, an
  // oversized init that saturates, and pixel origins that saturate.
  task automatic test_register_extremes();
    set_geometry(0, 0, 0, 0);
    send_command(CMD_INIT, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 3, 2, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 0, 0, 0, 0, 0, 0);
    set_geometry(2047, 2047, 127, 127);
    send_command(CMD_INIT, 0, 0, 0, 0, 0, 0);
    send_command(CMD_OCCUPY, 0, 0, 0, 0, 40, 40);
    send_command(CMD_ALLOC, 1, 1, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 2047, 2048, 0, 0, 0, 0);
    send_command(CMD_OCCUPY, 0, 0, 0, 40, 64, 24);
    send_command(CMD_ALLOC, 4094, 1, 0, 0, 0, 0);
    set_geometry(1024, 1024, 64, 64);
    send_command(CMD_INIT, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    send_command(CMD_ALLOC, 1, 1, 0, 0, 0, 0);
  endtask

  // Mostly well-formed traffic on a grid of moderate size: allocations that
  // fit the blocks, frees and occupies inside the grid, and an occasional
  // init; the rest uses the full field ranges.
  task automatic test_random_traffic(int unsigned count);
    int unsigned pick, bw, bh, c0, r0;
    bw = (blk_w == 0) ? 1 : blk_w;
    bh = (blk_h == 0) ? 1 : blk_h;
    send_command(CMD_INIT, 0, 0, 0, 0, 0, 0);
    repeat (count) begin
      pick = $urandom_range(99);
      c0 = (grid_c == 0) ? 0 : $urandom_range(grid_c - 1);
      r0 = (grid_r == 0) ? 0 : $urandom_range(grid_r - 1);
      if (pick < 6) begin
        send_command(CMD_INIT, $urandom, $urandom, $urandom, $urandom, 0, 0);
      end else if (pick < 50) begin
        send_command(CMD_ALLOC, $urandom_range(0, 4 * bw), $urandom_range(0, 4 * bh),
                     $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 56) begin
        send_command(CMD_ALLOC, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                     0, 0, 0, 0);
      end else if (pick < 80) begin
        send_command(CMD_FREE, $urandom, $urandom, c0, r0,
                     $urandom_range(0, 6), $urandom_range(0, 6));
      end else if (pick < 92) begin
        send_command(CMD_OCCUPY, $urandom, $urandom, c0, r0,
                     $urandom_range(0, 4), $urandom_range(0, 4));
      end else begin
        send_command(($urandom_range(1)) ? CMD_FREE : CMD_OCCUPY, $urandom, $urandom,
                     $urandom_range(63), $urandom_range(63),
                     $urandom_range(127), $urandom_range(127));
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering items, so the
  // result register and the working slot fill and the input stalls.
  task automatic test_result_backpressure();
    drop_valid();
    rx_hold_cycles = 400;
    repeat (8) send_command(CMD_ALLOC, 16, 16, 0, 0, 0, 0);
    send_command(CMD_FREE, 0, 0, 0, 0, 64, 64);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_addr_i       <= REG_BLOCK_W;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    command_i        <= CMD_INIT;
    request_width_i  <= '0;
    request_height_i <= '0;
    start_col_i      <= '0;
    start_row_i      <= '0;
    span_cols_i      <= '0;
    span_rows_i      <= '0;
    out_stall_i      = 1'b0;
    rx_hold_cycles   = 0;
    idle_count       = 0;
    error_count      = 0;
    foreach (occ_map[i]) occ_map[i] = '0;
    grid_c = 0;
    grid_r = 0;
    blk_w  = 16;
    blk_h  = 16;
    init_c = 8;
    init_r = 8;
    tx_idle_pct = 24;
    rx_idle_pct = 63;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_result_backpressure();

    // Three pacing phases, each across a few geometries.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 63 : 0;
      rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 24 : 0;
      set_geometry(16, 16, 8, 8);
      test_random_traffic(80);
      set_geometry(1, 1, 4, 4);
      test_random_traffic(60);
      set_geometry($urandom_range(1, 1024), $urandom_range(1, 1024),
                   $urandom_range(0, 16), $urandom_range(0, 16));
      test_random_traffic(70);
    end
    test_result_backpressure();

    drop_valid();
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/gba_pkg.sv
rtl/gba_ram.sv
rtl/gba_div.sv
rtl/gba_datapath.sv
rtl/gba_ctrl.sv
rtl/grid_block_allocator.sv
rtl/gba_checker.sv
tb/tb_grid_block_allocator.sv
